// ===== hdl/bce_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and arithmetic helpers for the Bezier curve evaluator.
// No dependencies; imported by every module under hdl/.
package bce_pkg;

    localparam int MAX_DEGREE = 4;
    localparam int NPTS       = MAX_DEGREE + 1;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEGREE = 2'd0;
    localparam logic [1:0] CFG_START  = 2'd1;
    localparam logic [1:0] CFG_INVDUR = 2'd2;

    // Item actions
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    // Derivative orders
    localparam logic [1:0] ORD_POS = 2'd0;
    localparam logic [1:0] ORD_VEL = 2'd1;
    localparam logic [1:0] ORD_ACC = 2'd2;

    localparam logic signed [31:0] Q16_ONE = 32'sh0001_0000;

    typedef logic signed [31:0] t_q16;
    typedef t_q16 [2:0]         t_vec;   // x, y, z
    typedef t_q16 [NPTS-1:0]    t_pw;    // powers of s, index 0 is 1.0

    // Control bundle that travels with each item down the pipe
    typedef struct packed {
        logic       vld;
        logic       eval;
        logic [2:0] idx;
        logic [2:0] n;
        logic [1:0] d;
        logic       ov;
    } t_ctl;

    typedef struct packed {
        logic ov;
        t_q16 v;
    } t_sat;

    // Bernstein power-basis matrices: [degree][point][power]
    localparam logic signed [4:0] BERN [0:4][0:4][0:4] = '{
        '{'{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0},
          '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}},
        '{'{1, -1, 0, 0, 0}, '{0, 1, 0, 0, 0}, '{0, 0, 0, 0, 0},
          '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}},
        '{'{1, -2, 1, 0, 0}, '{0, 2, -2, 0, 0}, '{0, 0, 1, 0, 0},
          '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}},
        '{'{1, -3, 3, -1, 0}, '{0, 3, -6, 3, 0}, '{0, 0, 3, -3, 0},
          '{0, 0, 0, 1, 0}, '{0, 0, 0, 0, 0}},
        '{'{1, -4, 6, -4, 1}, '{0, 4, -12, 12, -4}, '{0, 0, 6, -12, 6},
          '{0, 0, 0, 4, -4}, '{0, 0, 0, 0, 1}}
    };

    // Clamp to 32-bit signed range, flag when clamped
    function automatic t_sat sat32(input logic signed [67:0] a);
        t_sat r;
        if (a > 68'sh0_0000_0000_7FFF_FFFF) begin
            r.ov = 1'b1;
            r.v  = 32'sh7FFF_FFFF;
        end else if (a < -68'sh0_0000_0000_8000_0000) begin
            r.ov = 1'b1;
            r.v  = -32'sh8000_0000;
        end else begin
            r.ov = 1'b0;
            r.v  = a[31:0];
        end
        return r;
    endfunction

    // Control bundle with a new overflow flag
    function automatic t_ctl ctl_ov(input t_ctl c, input logic ov);
        t_ctl r;
        r    = c;
        r.ov = ov;
        return r;
    endfunction

    // Control bundle with a new valid bit
    function automatic t_ctl ctl_vld(input t_ctl c, input logic vld);
        t_ctl r;
        r     = c;
        r.vld = vld;
        return r;
    endfunction

    // Weight coefficient of power k for point i: matrix entry times j!/(j-d)!
    function automatic logic signed [8:0] wcoef(input logic [2:0] n, input logic [1:0] d,
                                                input logic [2:0] i, input logic [2:0] k);
        logic [3:0]        j;
        logic [8:0]        ju;
        logic signed [8:0] m;
        logic signed [8:0] f;
        j  = 4'(k) + 4'(d);
        ju = 9'(j);
        if (j > 4'(n) || i > n) begin
            return '0;
        end
        m = 9'(BERN[n][i][j[2:0]]);
        case (d)
            ORD_POS: f = 9'sd1;
            ORD_VEL: f = $signed(ju);
            default: f = $signed(9'(ju * (ju - 9'd1)));
        endcase
        return 9'(m * f);
    endfunction

endpackage

// ===== hdl/bezier_curve_evaluator.sv =====
`timescale 1ns / 1ps
// Bezier curve evaluator, degree 1 to 4, 3-D, Q16.16. Load items (action 0) write one
// control point; evaluate items (action 1) return position, velocity or acceleration at
// eval_time, one result each, and loads return nothing. The block is a 13-stage pipeline
// that accepts one item per clock while the output is not stalled, and the whole pipe holds
// while a result waits. The stages include a chain of three power multiplies and two
// derivative scalings. Configuration (degree, start_time, inverse_duration) must be written
// by the user only while no item is in flight; the block itself does not enforce it.
// Depends on bce_pkg, bce_time, bce_power, bce_comb, bce_scale.
module bezier_curve_evaluator import bce_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // Input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [2:0]  i_point_index,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    input  logic signed [31:0] i_eval_time,
    input  logic [1:0]  i_derivative_order,
    // Result items
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic        o_overflow
);

    logic [2:0]  r_degree;
    t_q16        r_start;
    logic [31:0] r_invdur;

    logic        en;
    t_ctl        ctl_t, ctl_p, ctl_c, ctl_s;
    t_vec        pt_t, pt_p;
    t_q16        s_t;
    t_pw         pw_p;
    t_vec        v_c, v_s;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= 3'(MAX_DEGREE);
            r_start  <= '0;
            r_invdur <= 32'h0001_0000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEGREE: r_degree <= i_cfg_data[2:0];
                CFG_START:  r_start  <= $signed(i_cfg_data);
                CFG_INVDUR: r_invdur <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Whole pipe advances unless a finished result is stalled
    assign en         = !ctl_s.vld || i_out_ready;
    assign o_in_ready = en;

    bce_time u_time (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (i_in_valid),
        .i_action (i_action),
        .i_idx    (i_point_index),
        .i_pt     ({i_coord_z, i_coord_y, i_coord_x}),
        .i_time   (i_eval_time),
        .i_order  (i_derivative_order),
        .i_degree (r_degree),
        .i_start  (r_start),
        .i_invdur (r_invdur),
        .o_ctl    (ctl_t),
        .o_pt     (pt_t),
        .o_s      (s_t)
    );

    bce_power u_power (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (ctl_t),
        .i_pt    (pt_t),
        .i_s     (s_t),
        .o_ctl   (ctl_p),
        .o_pt    (pt_p),
        .o_pw    (pw_p)
    );

    bce_comb u_comb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (ctl_p),
        .i_pt    (pt_p),
        .i_pw    (pw_p),
        .o_ctl   (ctl_c),
        .o_v     (v_c)
    );

    bce_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctl    (ctl_c),
        .i_v      (v_c),
        .i_invdur (r_invdur),
        .o_ctl    (ctl_s),
        .o_v      (v_s)
    );

    assign o_out_valid = ctl_s.vld;
    assign o_out_x     = v_s[0];
    assign o_out_y     = v_s[1];
    assign o_out_z     = v_s[2];
    assign o_overflow  = ctl_s.ov;

`ifndef ASSERT_OFF
    // Load items are dropped at the store and never reach the scaler
    a_no_load_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_c.vld |-> ctl_c.eval == ACT_EVAL)
        else $error("load item reached the scaling stages");

    // Clamped degree at the output is always a legal degree
    a_degree_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_s.vld |-> (ctl_s.n >= 3'd1) && (ctl_s.n <= 3'(MAX_DEGREE)))
        else $error("illegal degree carried with result");

    // Nothing comes out in the cycle after reset
    a_reset_flush: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");
`endif

endmodule

// ===== hdl/bce_time.sv =====
`timescale 1ns / 1ps
// Time front end: clamps degree/order and forms s = (t - start) * inv_duration.
// Depends on bce_pkg. Three register stages.
module bce_time import bce_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic        i_action,
    input  logic [2:0]  i_idx,
    input  t_vec        i_pt,
    input  t_q16        i_time,
    input  logic [1:0]  i_order,
    input  logic [2:0]  i_degree,
    input  t_q16        i_start,
    input  logic [31:0] i_invdur,
    output t_ctl        o_ctl,
    output t_vec        o_pt,
    output t_q16        o_s
);

    t_ctl               r1_ctl, r2_ctl, r3_ctl;
    t_vec               r1_pt, r2_pt, r3_pt;
    logic [32:0]        r1_mag;
    logic               r1_neg, r2_neg;
    logic [64:0]        r2_prod;
    t_q16               r3_s;

    t_ctl               n_ctl1;
    logic signed [32:0] n_diff;
    logic [48:0]        n_qpos;
    logic [49:0]        n_qneg;
    t_q16               n_s;
    logic               n_sov;

    // Stage 1: clamp codes, signed difference and its magnitude
    always_comb begin
        n_ctl1.vld  = i_vld;
        n_ctl1.eval = i_action;
        n_ctl1.idx  = i_idx;
        n_ctl1.ov   = 1'b0;
        if (i_degree == 3'd0) begin
            n_ctl1.n = 3'd1;
        end else if (i_degree > 3'(MAX_DEGREE)) begin
            n_ctl1.n = 3'(MAX_DEGREE);
        end else begin
            n_ctl1.n = i_degree;
        end
        n_ctl1.d = (i_order > ORD_ACC) ? ORD_ACC : i_order;
        n_diff   = 33'(i_time) - 33'(i_start);
    end

    // Stage 3: floor and clamp of the scaled time
    always_comb begin
        n_qpos = r2_prod[64:16];
        n_qneg = 50'((66'(r2_prod) + 66'd65535) >> 16);
        n_sov  = 1'b0;
        if (!r2_neg) begin
            if (n_qpos > 49'h0_7FFF_FFFF) begin
                n_sov = 1'b1;
                n_s   = 32'sh7FFF_FFFF;
            end else begin
                n_s   = $signed(n_qpos[31:0]);
            end
        end else begin
            if (n_qneg > 50'h0_8000_0000) begin
                n_sov = 1'b1;
                n_s   = -32'sh8000_0000;
            end else begin
                n_s   = $signed(~n_qneg[31:0] + 32'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl.vld <= 1'b0;
            r2_ctl.vld <= 1'b0;
            r3_ctl.vld <= 1'b0;
        end else if (i_en) begin
            r1_ctl <= n_ctl1;
            r1_pt  <= i_pt;
            r1_neg <= n_diff[32];
            r1_mag <= n_diff[32] ? 33'(-n_diff) : 33'(n_diff);
            r2_ctl  <= r1_ctl;
            r2_pt   <= r1_pt;
            r2_neg  <= r1_neg;
            r2_prod <= 65'(r1_mag) * 65'(i_invdur);
            r3_ctl    <= ctl_ov(r2_ctl, n_sov);
            r3_pt     <= r2_pt;
            r3_s      <= n_s;
        end
    end

    assign o_ctl = r3_ctl;
    assign o_pt  = r3_pt;
    assign o_s   = r3_s;

endmodule

// ===== hdl/bce_power.sv =====
`timescale 1ns / 1ps
// Power chain: s^2, s^3, s^4 with Q16.16 floor and clamp, at most one multiply per stage.
// Depends on bce_pkg. Four register stages.
module bce_power import bce_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_ctl i_ctl,
    input  t_vec i_pt,
    input  t_q16 i_s,
    output t_ctl o_ctl,
    output t_vec o_pt,
    output t_pw  o_pw
);

    t_ctl               r4_ctl, r5_ctl, r6_ctl, r7_ctl;
    t_vec               r4_pt, r5_pt, r6_pt, r7_pt;
    t_q16               r4_s, r5_s, r6_s, r7_s;
    logic signed [63:0] r4_raw, r5_raw, r6_raw;
    t_q16               r5_p2, r6_p2, r7_p2;
    t_q16               r6_p3, r7_p3;
    t_q16               r7_p4;

    t_sat               n_p2, n_p3, n_p4;
    logic               n_use2, n_use3, n_use4;

    // Clamp each power; its flag counts only if that power is used
    always_comb begin
        n_p2   = sat32(68'(r4_raw >>> 16));
        n_p3   = sat32(68'(r5_raw >>> 16));
        n_p4   = sat32(68'(r6_raw >>> 16));
        n_use2 = (4'd2 + 4'(r4_ctl.d)) <= 4'(r4_ctl.n);
        n_use3 = (4'd3 + 4'(r5_ctl.d)) <= 4'(r5_ctl.n);
        n_use4 = (4'd4 + 4'(r6_ctl.d)) <= 4'(r6_ctl.n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctl.vld <= 1'b0;
            r5_ctl.vld <= 1'b0;
            r6_ctl.vld <= 1'b0;
            r7_ctl.vld <= 1'b0;
        end else if (i_en) begin
            r4_ctl <= i_ctl;
            r4_pt  <= i_pt;
            r4_s   <= i_s;
            r4_raw <= i_s * i_s;
            r5_ctl    <= ctl_ov(r4_ctl, r4_ctl.ov | (n_p2.ov & n_use2));
            r5_pt     <= r4_pt;
            r5_s      <= r4_s;
            r5_p2     <= n_p2.v;
            r5_raw    <= n_p2.v * r4_s;
            r6_ctl    <= ctl_ov(r5_ctl, r5_ctl.ov | (n_p3.ov & n_use3));
            r6_pt     <= r5_pt;
            r6_s      <= r5_s;
            r6_p2     <= r5_p2;
            r6_p3     <= n_p3.v;
            r6_raw    <= n_p3.v * r5_s;
            r7_ctl    <= ctl_ov(r6_ctl, r6_ctl.ov | (n_p4.ov & n_use4));
            r7_pt     <= r6_pt;
            r7_s      <= r6_s;
            r7_p2     <= r6_p2;
            r7_p3     <= r6_p3;
            r7_p4     <= n_p4.v;
        end
    end

    assign o_ctl = r7_ctl;
    assign o_pt  = r7_pt;
    assign o_pw  = {r7_p4, r7_p3, r7_p2, r7_s, Q16_ONE};

endmodule

// ===== hdl/bce_comb.sv =====
`timescale 1ns / 1ps
// Basis weights, control point store and weighted sum of the points.
// Depends on bce_pkg. Three register stages; loads write the store here.
module bce_comb import bce_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_ctl i_ctl,
    input  t_vec i_pt,
    input  t_pw  i_pw,
    output t_ctl o_ctl,
    output t_vec o_v
);

    t_vec               r_store [NPTS];
    t_ctl               r8_ctl, r9_ctl, r10_ctl;
    t_vec               r8_pt;
    t_q16               r8_w [NPTS];
    logic signed [47:0] r9_prod [NPTS][3];
    t_vec               r10_v;

    t_sat               n_w [NPTS];
    logic               n_wov;
    t_sat               n_v [3];
    logic               n_vov;

    // Stage 8: weight of each point from the power vector
    always_comb begin
        logic signed [43:0] acc;
        n_wov = 1'b0;
        for (int i = 0; i < NPTS; i++) begin
            acc = '0;
            for (int k = 0; k < NPTS; k++) begin
                acc = acc + 44'(wcoef(i_ctl.n, i_ctl.d, 3'(i), 3'(k)))
                          * 44'($signed(i_pw[k]));
            end
            n_w[i] = sat32(68'(acc));
            n_wov  = n_wov | n_w[i].ov;
        end
    end

    // Stage 10: sum of the weighted points per axis
    always_comb begin
        logic signed [50:0] sum;
        n_vov = 1'b0;
        for (int c = 0; c < 3; c++) begin
            sum = '0;
            for (int i = 0; i < NPTS; i++) begin
                sum = sum + 51'(r9_prod[i][c]);
            end
            n_v[c] = sat32(68'(sum));
            n_vov  = n_vov | n_v[c].ov;
        end
    end

    // Control point store, written by load items leaving stage 8
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NPTS; i++) begin
                r_store[i] <= '0;
            end
        end else if (i_en && r8_ctl.vld && (r8_ctl.eval == ACT_LOAD)
                     && (r8_ctl.idx <= 3'(MAX_DEGREE))) begin
            r_store[r8_ctl.idx] <= r8_pt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_ctl.vld  <= 1'b0;
            r9_ctl.vld  <= 1'b0;
            r10_ctl.vld <= 1'b0;
        end else if (i_en) begin
            r8_ctl    <= ctl_ov(i_ctl, i_ctl.ov | n_wov);
            r8_pt     <= i_pt;
            r8_w      <= '{n_w[0].v, n_w[1].v, n_w[2].v, n_w[3].v, n_w[4].v};
            r9_ctl     <= ctl_vld(r8_ctl, r8_ctl.vld & (r8_ctl.eval == ACT_EVAL));
            for (int i = 0; i < NPTS; i++) begin
                for (int c = 0; c < 3; c++) begin
                    r9_prod[i][c] <= 48'((64'(r_store[i][c]) * 64'(r8_w[i])) >>> 16);
                end
            end
            r10_ctl    <= ctl_ov(r9_ctl, r9_ctl.ov | n_vov);
            r10_v      <= {n_v[2].v, n_v[1].v, n_v[0].v};
        end
    end

    assign o_ctl = r10_ctl;
    assign o_v   = r10_v;

endmodule

// ===== hdl/bce_scale.sv =====
`timescale 1ns / 1ps
// Derivative scaling: multiplies by inv_duration once per derivative order.
// Depends on bce_pkg. Three register stages.
module bce_scale import bce_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_ctl        i_ctl,
    input  t_vec        i_v,
    input  logic [31:0] i_invdur,
    output t_ctl        o_ctl,
    output t_vec        o_v
);

    t_ctl               r11_ctl, r12_ctl, r13_ctl;
    t_vec               r11_v, r12_v, r13_v;
    logic signed [64:0] r11_raw [3];
    logic signed [64:0] r12_raw [3];

    logic signed [32:0] n_inv;
    t_sat               n_s1 [3];
    t_sat               n_s2 [3];
    t_vec               n_v1, n_v2;
    logic               n_ov1, n_ov2;

    // First and second scaling passes, bypassed for lower orders
    always_comb begin
        n_inv = $signed({1'b0, i_invdur});
        n_ov1 = 1'b0;
        n_ov2 = 1'b0;
        for (int c = 0; c < 3; c++) begin
            n_s1[c] = sat32(68'(r11_raw[c] >>> 16));
            n_s2[c] = sat32(68'(r12_raw[c] >>> 16));
            if (r11_ctl.d != ORD_POS) begin
                n_v1[c] = n_s1[c].v;
                n_ov1   = n_ov1 | n_s1[c].ov;
            end else begin
                n_v1[c] = r11_v[c];
            end
            if (r12_ctl.d == ORD_ACC) begin
                n_v2[c] = n_s2[c].v;
                n_ov2   = n_ov2 | n_s2[c].ov;
            end else begin
                n_v2[c] = r12_v[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_ctl.vld <= 1'b0;
            r12_ctl.vld <= 1'b0;
            r13_ctl.vld <= 1'b0;
        end else if (i_en) begin
            r11_ctl <= i_ctl;
            r11_v   <= i_v;
            for (int c = 0; c < 3; c++) begin
                r11_raw[c] <= $signed(i_v[c]) * n_inv;
                r12_raw[c] <= $signed(n_v1[c]) * n_inv;
            end
            r12_ctl    <= ctl_ov(r11_ctl, r11_ctl.ov | n_ov1);
            r12_v      <= n_v1;
            r13_ctl    <= ctl_ov(r12_ctl, r12_ctl.ov | n_ov2);
            r13_v      <= n_v2;
        end
    end

    assign o_ctl = r13_ctl;
    assign o_v   = r13_v;

endmodule
